// File: design/lqs_pkg.sv
// Package for the lottery quantum scheduler.
// Holds table sizes, the result kind codes and the table entry type.
// Depends on nothing.
package lqs_pkg;

    localparam int ENTRIES    = 16;
    localparam int COUNT_BITS = 32;
    localparam int IDX_W      = $clog2(ENTRIES);
    localparam int CNT_W      = $clog2(ENTRIES + 1);
    localparam int TOT_W      = 8 + IDX_W;
    localparam int RND_W      = 32;
    localparam int DIV_STEP   = 4;
    localparam int DIV_ITER   = RND_W / DIV_STEP;
    localparam int DIVC_W     = $clog2(DIV_ITER);
    localparam logic [7:0] QUANTUM_RESET = 8'd5;

    typedef enum logic [2:0] {
        KIND_ACCEPT = 3'd0,
        KIND_FULL   = 3'd1,
        KIND_FINISH = 3'd2,
        KIND_RUN    = 3'd3,
        KIND_IDLE   = 3'd4
    } kind_t;

    typedef struct packed {
        logic [15:0]           id;
        logic [7:0]            tickets;
        logic [15:0]           remaining;
        logic [COUNT_BITS-1:0] wait_cnt;
        logic [COUNT_BITS-1:0] total_cnt;
    } entry_t;

endpackage

// File: design/lottery_quantum_scheduler_core.sv
// Lottery scheduler with a time quantum: job table, draw and run sweeps.
// Depends on lqs_pkg (sizes, kind codes, entry type).
// An arrival is handled in ST_ARRIVE and its result is registered. A tick runs
// a compaction sweep if a job finishes, then the sum sweep, divide and walk
// sweep when a draw is due, and the run sweep over N jobs; all sweeps share
// the single read port of the job memory. One request at a time (busy).
// Reset clears control state only; the job memory holds no reset value.
// Results are strobed for one cycle on result_valid; the receiver cannot stall.
module lottery_quantum_scheduler_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        action,
    input  logic [15:0] job_id,
    input  logic [7:0]  job_priority,
    input  logic [15:0] job_run_time,
    input  logic [31:0] random_value,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    output logic        result_valid,
    output logic [2:0]  kind,
    output logic [15:0] out_id,
    output logic [31:0] wait_count,
    output logic [31:0] turnaround_count,
    output logic        last
);

    // One-hot sequencer states.
    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_ARRIVE = 9'b000000010,
        ST_TICK   = 9'b000000100,
        ST_CHECK  = 9'b000001000,
        ST_SHIFT  = 9'b000010000,
        ST_SUM    = 9'b000100000,
        ST_DIV    = 9'b001000000,
        ST_WALK   = 9'b010000000,
        ST_RUN    = 9'b100000000
    } state_t;

    // Job memory: one write port, one registered read port.
    lqs_pkg::entry_t mem [lqs_pkg::ENTRIES];
    lqs_pkg::entry_t rd_data_reg;
    logic                     mem_we;
    logic [lqs_pkg::IDX_W-1:0] mem_wa;
    logic [lqs_pkg::IDX_W-1:0] mem_ra;
    lqs_pkg::entry_t          mem_wd;

    state_t state_reg, state_next;
    logic [lqs_pkg::CNT_W-1:0] count_reg, count_next;
    logic [lqs_pkg::IDX_W-1:0] run_slot_reg, run_slot_next;
    logic run_valid_reg, run_valid_next;
    logic [7:0] qused_reg, qused_next;
    logic [7:0] quantum_reg, quantum_next;

    // Captured request.
    logic        act_reg, act_next;
    logic [15:0] id_reg, id_next;
    logic [7:0]  prio_reg, prio_next;
    logic [15:0] rt_reg, rt_next;
    logic [lqs_pkg::RND_W-1:0] rnd_reg, rnd_next;

    // Sweep control: read pointer runs one entry ahead of the processed one.
    logic [lqs_pkg::CNT_W-1:0]  rd_idx_reg, rd_idx_next;
    logic                       pend_reg, pend_next;
    logic [lqs_pkg::IDX_W-1:0]  pidx_reg, pidx_next;
    logic [lqs_pkg::TOT_W-1:0]  total_reg, total_next;
    logic [lqs_pkg::TOT_W-1:0]  rem_reg, rem_next;
    logic [lqs_pkg::DIVC_W-1:0] divc_reg, divc_next;
    logic                       found_reg, found_next;
    logic [15:0]                run_id_reg, run_id_next;

    // Result registers.
    logic        res_valid_reg, res_valid_next;
    lqs_pkg::kind_t kind_reg, kind_next;
    logic [15:0] out_id_reg, out_id_next;
    logic [31:0] wait_reg, wait_next;
    logic [31:0] turn_reg, turn_next;
    logic        last_reg, last_next;

    // Scratch for the comb block.
    logic [lqs_pkg::TOT_W-1:0] dv_r;
    logic [lqs_pkg::TOT_W:0]   dv_t;
    logic [lqs_pkg::RND_W-1:0] dv_rnd;
    logic                      issue;
    logic                      rs_in_range;
    lqs_pkg::entry_t           ent;

    assign busy             = (state_reg != ST_IDLE);
    assign cfg_ready        = (state_reg == ST_IDLE);
    assign result_valid     = res_valid_reg;
    assign kind             = kind_reg;
    assign out_id           = out_id_reg;
    assign wait_count       = wait_reg;
    assign turnaround_count = turn_reg;
    assign last             = last_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[mem_ra];
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        run_slot_next  = run_slot_reg;
        run_valid_next = run_valid_reg;
        qused_next     = qused_reg;
        quantum_next   = quantum_reg;
        act_next       = act_reg;
        id_next        = id_reg;
        prio_next      = prio_reg;
        rt_next        = rt_reg;
        rnd_next       = rnd_reg;
        rd_idx_next    = rd_idx_reg;
        pend_next      = 1'b0;
        pidx_next      = pidx_reg;
        total_next     = total_reg;
        rem_next       = rem_reg;
        divc_next      = divc_reg;
        found_next     = found_reg;
        run_id_next    = run_id_reg;
        res_valid_next = 1'b0;
        kind_next      = kind_reg;
        out_id_next    = out_id_reg;
        wait_next      = wait_reg;
        turn_next      = turn_reg;
        last_next      = last_reg;
        mem_we         = 1'b0;
        mem_wa         = pidx_reg;
        mem_wd         = rd_data_reg;
        mem_ra         = rd_idx_reg[lqs_pkg::IDX_W-1:0];
        issue          = 1'b0;
        ent            = rd_data_reg;
        dv_r           = rem_reg;
        dv_t           = '0;
        dv_rnd         = rnd_reg;
        rs_in_range    = (lqs_pkg::CNT_W'(run_slot_reg) < count_reg);

        if (cfg_valid && cfg_ready)
        begin
            quantum_next = cfg_data;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    act_next  = action;
                    id_next   = job_id;
                    prio_next = job_priority;
                    rt_next   = job_run_time;
                    rnd_next  = random_value;
                    state_next = action ? ST_TICK : ST_ARRIVE;
                end
            end

            ST_ARRIVE:
            begin
                res_valid_next = 1'b1;
                out_id_next    = id_reg;
                wait_next      = '0;
                turn_next      = '0;
                last_next      = 1'b1;
                if (count_reg >= lqs_pkg::CNT_W'(lqs_pkg::ENTRIES))
                begin
                    kind_next = lqs_pkg::KIND_FULL;
                end
                else
                begin
                    kind_next        = lqs_pkg::KIND_ACCEPT;
                    mem_we           = 1'b1;
                    mem_wa           = count_reg[lqs_pkg::IDX_W-1:0];
                    mem_wd.id        = id_reg;
                    mem_wd.tickets   = prio_reg;
                    mem_wd.remaining = rt_reg;
                    mem_wd.wait_cnt  = '0;
                    mem_wd.total_cnt = '0;
                    count_next       = count_reg + 1'b1;
                end
                state_next = ST_IDLE;
            end

            ST_TICK:
            begin
                rd_idx_next = '0;
                if (run_valid_reg && rs_in_range)
                begin
                    mem_ra     = run_slot_reg;
                    state_next = ST_CHECK;
                end
                else
                begin
                    run_valid_next = 1'b0;
                    total_next     = '0;
                    state_next     = (count_reg != '0) ? ST_SUM : ST_RUN;
                end
            end

            ST_CHECK:
            begin
                // Running entry is in the read register now.
                rd_idx_next = '0;
                total_next  = '0;
                if (rd_data_reg.remaining == '0)
                begin
                    res_valid_next = 1'b1;
                    kind_next      = lqs_pkg::KIND_FINISH;
                    out_id_next    = rd_data_reg.id;
                    wait_next      = rd_data_reg.wait_cnt;
                    turn_next      = rd_data_reg.total_cnt;
                    last_next      = 1'b0;
                    run_valid_next = 1'b0;
                    rd_idx_next    = lqs_pkg::CNT_W'(run_slot_reg) + 1'b1;
                    state_next     = ST_SHIFT;
                end
                else if (qused_reg >= quantum_reg)
                begin
                    state_next = ST_SUM;
                end
                else
                begin
                    state_next = ST_RUN;
                end
            end

            ST_SHIFT:
            begin
                // Compact: entry i+1 moves to i.
                issue = (rd_idx_reg < count_reg);
                if (pend_reg)
                begin
                    mem_we = 1'b1;
                    mem_wa = pidx_reg - 1'b1;
                    mem_wd = rd_data_reg;
                end
                if (issue)
                begin
                    pend_next   = 1'b1;
                    pidx_next   = rd_idx_reg[lqs_pkg::IDX_W-1:0];
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
                else if (!pend_reg)
                begin
                    count_next  = count_reg - 1'b1;
                    rd_idx_next = '0;
                    total_next  = '0;
                    state_next  = (count_reg > lqs_pkg::CNT_W'(1)) ? ST_SUM : ST_RUN;
                end
            end

            ST_SUM:
            begin
                issue = (rd_idx_reg < count_reg);
                if (pend_reg)
                begin
                    total_next = total_reg + lqs_pkg::TOT_W'(rd_data_reg.tickets);
                end
                if (issue)
                begin
                    pend_next   = 1'b1;
                    pidx_next   = rd_idx_reg[lqs_pkg::IDX_W-1:0];
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
                else if (!pend_reg)
                begin
                    rd_idx_next = '0;
                    if (total_reg == '0)
                    begin
                        // No tickets at all: slot 0 wins.
                        run_slot_next  = '0;
                        run_valid_next = 1'b1;
                        qused_next     = '0;
                        state_next     = ST_RUN;
                    end
                    else
                    begin
                        rem_next   = '0;
                        divc_next  = '0;
                        state_next = ST_DIV;
                    end
                end
            end

            ST_DIV:
            begin
                // Restoring remainder, DIV_STEP bits per cycle, MSB first.
                for (int k = 0; k < lqs_pkg::DIV_STEP; k++)
                begin
                    dv_t   = {dv_r, dv_rnd[lqs_pkg::RND_W-1]};
                    dv_rnd = dv_rnd << 1;
                    if (dv_t >= {1'b0, total_reg})
                    begin
                        dv_t = dv_t - {1'b0, total_reg};
                    end
                    dv_r = dv_t[lqs_pkg::TOT_W-1:0];
                end
                rnd_next  = dv_rnd;
                rem_next  = dv_r;
                divc_next = divc_reg + 1'b1;
                if (divc_reg == lqs_pkg::DIVC_W'(lqs_pkg::DIV_ITER - 1))
                begin
                    rem_next    = dv_r + 1'b1;  // winning ticket number
                    found_next  = 1'b0;
                    rd_idx_next = '0;
                    state_next  = ST_WALK;
                end
            end

            ST_WALK:
            begin
                issue = (rd_idx_reg < count_reg) && !found_reg;
                if (pend_reg && !found_reg)
                begin
                    if (rem_reg <= lqs_pkg::TOT_W'(rd_data_reg.tickets))
                    begin
                        run_slot_next = pidx_reg;
                        found_next    = 1'b1;
                    end
                    else
                    begin
                        rem_next = rem_reg - lqs_pkg::TOT_W'(rd_data_reg.tickets);
                    end
                end
                if (issue)
                begin
                    pend_next   = 1'b1;
                    pidx_next   = rd_idx_reg[lqs_pkg::IDX_W-1:0];
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
                else if (!pend_reg)
                begin
                    if (!found_reg)
                    begin
                        run_slot_next = lqs_pkg::IDX_W'(count_reg - 1'b1);
                    end
                    run_valid_next = 1'b1;
                    qused_next     = '0;
                    rd_idx_next    = '0;
                    state_next     = ST_RUN;
                end
            end

            ST_RUN:
            begin
                if (!(run_valid_reg && (count_reg != '0)))
                begin
                    res_valid_next = 1'b1;
                    kind_next      = lqs_pkg::KIND_IDLE;
                    out_id_next    = '0;
                    wait_next      = '0;
                    turn_next      = '0;
                    last_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    issue = (rd_idx_reg < count_reg);
                    if (pend_reg)
                    begin
                        ent = rd_data_reg;
                        if (pidx_reg == run_slot_reg)
                        begin
                            run_id_next = rd_data_reg.id;
                            if (ent.remaining != '0)
                            begin
                                ent.remaining = ent.remaining - 1'b1;
                            end
                        end
                        else if (ent.wait_cnt != '1)
                        begin
                            ent.wait_cnt = ent.wait_cnt + 1'b1;
                        end
                        if (ent.total_cnt != '1)
                        begin
                            ent.total_cnt = ent.total_cnt + 1'b1;
                        end
                        mem_we = 1'b1;
                        mem_wa = pidx_reg;
                        mem_wd = ent;
                    end
                    if (issue)
                    begin
                        pend_next   = 1'b1;
                        pidx_next   = rd_idx_reg[lqs_pkg::IDX_W-1:0];
                        rd_idx_next = rd_idx_reg + 1'b1;
                    end
                    else if (!pend_reg)
                    begin
                        if (qused_reg != 8'hFF)
                        begin
                            qused_next = qused_reg + 1'b1;
                        end
                        res_valid_next = 1'b1;
                        kind_next      = lqs_pkg::KIND_RUN;
                        out_id_next    = run_id_reg;
                        wait_next      = '0;
                        turn_next      = '0;
                        last_next      = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            run_slot_reg  <= '0;
            run_valid_reg <= 1'b0;
            qused_reg     <= 8'd1;
            quantum_reg   <= lqs_pkg::QUANTUM_RESET;
            pend_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            run_slot_reg  <= run_slot_next;
            run_valid_reg <= run_valid_next;
            qused_reg     <= qused_next;
            quantum_reg   <= quantum_next;
            pend_reg      <= pend_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload and datapath registers.
    always_ff @(posedge clk)
    begin
        act_reg     <= act_next;
        id_reg      <= id_next;
        prio_reg    <= prio_next;
        rt_reg      <= rt_next;
        rnd_reg     <= rnd_next;
        rd_idx_reg  <= rd_idx_next;
        pidx_reg    <= pidx_next;
        total_reg   <= total_next;
        rem_reg     <= rem_next;
        divc_reg    <= divc_next;
        found_reg   <= found_next;
        run_id_reg  <= run_id_next;
        kind_reg    <= kind_next;
        out_id_reg  <= out_id_next;
        wait_reg    <= wait_next;
        turn_reg    <= turn_next;
        last_reg    <= last_next;
    end

endmodule

// File: verif/lqs_checker.sv
// Checker for the lottery quantum scheduler: watches the request, config and
// result channels, predicts every result and compares it field by field.
// Depends on lqs_pkg (kind codes, table size).
module lqs_checker
    import lqs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        action,
    input  logic [15:0] job_id,
    input  logic [7:0]  job_priority,
    input  logic [15:0] job_run_time,
    input  logic [31:0] random_value,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    input  logic        result_valid,
    input  logic [2:0]  kind,
    input  logic [15:0] out_id,
    input  logic [31:0] wait_count,
    input  logic [31:0] turnaround_count,
    input  logic        last,
    output int          fails,
    output int          pending
);

    typedef struct {
        kind_t       k;
        logic [15:0] id;
        logic [31:0] w;
        logic [31:0] t;
        logic        l;
    } sched_result_t;

    sched_result_t expected_results[$];

    logic [15:0] tbl_id [ENTRIES];
    logic [7:0]  tbl_tickets [ENTRIES];
    logic [15:0] tbl_left [ENTRIES];
    logic [31:0] tbl_wait [ENTRIES];
    logic [31:0] tbl_turn [ENTRIES];
    int          jobs;
    int          cur_slot;
    bit          cur_valid;
    logic [7:0]  slice_used;
    logic [7:0]  slice_len;

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $realtime, msg);
        fails++;
    endtask

    task automatic push_result(input kind_t k, input logic [15:0] id,
                               input logic [31:0] w, input logic [31:0] t);
        sched_result_t r;
        r.k = k;
        r.id = id;
        r.w = w;
        r.t = t;
        r.l = 1'b0;
        expected_results.push_back(r);
    endtask

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    task automatic lottery_draw(input logic [31:0] rnd);
        logic [31:0] total;
        logic [31:0] win;
        bit          found;
        total = 0;
        found = 0;
        for (int i = 0; i < jobs; i++)
            total += tbl_tickets[i];
        cur_valid = 1;
        slice_used = 0;
        cur_slot = 0;
        if (total != 0) begin
            win = (rnd % total) + 32'd1;
            for (int i = 0; i < jobs; i++) begin
                if (!found) begin
                    if (win <= tbl_tickets[i]) begin
                        cur_slot = i;
                        found = 1;
                    end
                    else
                        win -= tbl_tickets[i];
                end
            end
            if (!found)
                cur_slot = jobs - 1;
        end
    endtask

    task automatic schedule_tick(input logic [31:0] rnd);
        if (cur_valid && cur_slot >= jobs)
            cur_valid = 0;
        if (cur_valid) begin
            if (tbl_left[cur_slot] == 0) begin
                push_result(KIND_FINISH, tbl_id[cur_slot], tbl_wait[cur_slot],
                            tbl_turn[cur_slot]);
                // compact the table over the retired slot
                for (int i = cur_slot; i + 1 < jobs; i++) begin
                    tbl_id[i] = tbl_id[i+1];
                    tbl_tickets[i] = tbl_tickets[i+1];
                    tbl_left[i] = tbl_left[i+1];
                    tbl_wait[i] = tbl_wait[i+1];
                    tbl_turn[i] = tbl_turn[i+1];
                end
                jobs--;
                cur_valid = 0;
                if (jobs > 0)
                    lottery_draw(rnd);
            end
            else if (slice_used >= slice_len)
                lottery_draw(rnd);
        end
        else if (jobs > 0)
            lottery_draw(rnd);

        if (cur_valid && jobs > 0) begin
            if (tbl_left[cur_slot] != 0)
                tbl_left[cur_slot]--;
            if (slice_used != 8'd255)
                slice_used++;
            for (int i = 0; i < jobs; i++) begin
                if (i != cur_slot)
                    tbl_wait[i] = sat_inc(tbl_wait[i]);
                tbl_turn[i] = sat_inc(tbl_turn[i]);
            end
            push_result(KIND_RUN, tbl_id[cur_slot], 0, 0);
        end
        else
            push_result(KIND_IDLE, 0, 0, 0);
    endtask

    always @(posedge clk or negedge rst_n) begin
        sched_result_t e;
        if (!rst_n) begin
            jobs = 0;
            cur_slot = 0;
            cur_valid = 0;
            slice_used = 8'd1;
            slice_len = QUANTUM_RESET;
            expected_results.delete();
        end
        else begin
            if (cfg_valid && cfg_ready)
                slice_len = cfg_data;

            if (start && !busy) begin
                if (action == 1'b0) begin
                    if (jobs >= ENTRIES)
                        push_result(KIND_FULL, job_id, 0, 0);
                    else begin
                        tbl_id[jobs] = job_id;
                        tbl_tickets[jobs] = job_priority;
                        tbl_left[jobs] = job_run_time;
                        tbl_wait[jobs] = 0;
                        tbl_turn[jobs] = 0;
                        jobs++;
                        push_result(KIND_ACCEPT, job_id, 0, 0);
                    end
                end
                else
                    schedule_tick(random_value);
                expected_results[expected_results.size()-1].l = 1'b1;
            end

            if (result_valid) begin
                if (expected_results.size() == 0)
                    report_mismatch($sformatf("unexpected result kind %0d id %0h",
                                              kind, out_id));
                else begin
                    e = expected_results.pop_front();
                    if (kind !== e.k)
                        report_mismatch($sformatf("kind %0d, want %0d", kind, e.k));
                    if (out_id !== e.id)
                        report_mismatch($sformatf("out_id %0h, want %0h", out_id, e.id));
                    if (wait_count !== e.w)
                        report_mismatch($sformatf("wait_count %0d, want %0d",
                                                  wait_count, e.w));
                    if (turnaround_count !== e.t)
                        report_mismatch($sformatf("turnaround_count %0d, want %0d",
                                                  turnaround_count, e.t));
                    if (last !== e.l)
                        report_mismatch($sformatf("last %0b, want %0b", last, e.l));
                end
            end
        end
        pending = expected_results.size();
    end

endmodule

// File: verif/tb_lottery_quantum_scheduler_core.sv
// Testbench top for the lottery quantum scheduler core: drives requests and
// quantum writes, and gives the verdict from the checker's failure count.
// Depends on lqs_pkg, lottery_quantum_scheduler_core and lqs_checker.
module tb_lottery_quantum_scheduler_core;
    import lqs_pkg::*;

    localparam bit ACT_ARRIVE = 1'b0;
    localparam bit ACT_TICK   = 1'b1;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        action = ACT_ARRIVE;
    logic [15:0] job_id = '0;
    logic [7:0]  job_priority = '0;
    logic [15:0] job_run_time = '0;
    logic [31:0] random_value = '0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data = '0;
    logic        result_valid;
    logic [2:0]  kind;
    logic [15:0] out_id;
    logic [31:0] wait_count;
    logic [31:0] turnaround_count;
    logic        last;
    int          fails;
    int          pending;
    bit          gaps_on = 1;

    always #6 clk = ~clk;

    lottery_quantum_scheduler_core dut (.*);

    lqs_checker chk (.*);

    // Hold start high with the new request once the block is free. The
    // caller is at a falling edge where the previous request was driven.
    task automatic issue(input bit act, input logic [15:0] id, input logic [7:0] prio,
                         input logic [15:0] rt, input logic [31:0] rnd);
        @(negedge clk);
        while (busy) begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        action <= act;
        job_id <= id;
        job_priority <= prio;
        job_run_time <= rt;
        random_value <= rnd;
    endtask

    // Random idle burst on the request side, none in the final phase.
    task automatic maybe_gap();
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            @(negedge clk);
            start <= 1'b0;
            repeat ($urandom_range(0, 16)) @(negedge clk);
        end
    endtask

    // Drain: every expected result back and the block free again.
    task automatic wait_idle();
        @(negedge clk);
        start <= 1'b0;
        while (pending != 0 || busy)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_quantum(input logic [7:0] q);
        cfg_valid <= 1'b1;
        cfg_data <= q;
        while (!cfg_ready)
            @(negedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_item(input int arrive_pct);
        logic [15:0] rt;
        logic [7:0]  prio;
        rt = ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8));
        prio = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
        if ($urandom_range(0, 99) < arrive_pct)
            issue(ACT_ARRIVE, 16'($urandom), prio, rt, $urandom);
        else
            issue(ACT_TICK, 16'($urandom), 8'($urandom), 16'($urandom), $urandom);
        maybe_gap();
    endtask

    initial begin
        logic [7:0] quanta [6];
        quanta = '{8'd1, 8'd255, 8'd2, 8'd0, 8'd7, 8'd3};
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // Directed: zero tickets force slot 0, zero run time finishes on the
        // next tick, then a tick on an empty table.
        issue(ACT_ARRIVE, 16'h0001, 8'd0, 16'd0, 32'd0);
        issue(ACT_TICK, 16'h0000, 8'd0, 16'd0, 32'hFFFF_FFFF);
        issue(ACT_TICK, 16'h0000, 8'd0, 16'd0, 32'h0);
        issue(ACT_TICK, 16'hFFFF, 8'hFF, 16'hFFFF, 32'h1234_5678);
        // Field extremes, duplicate ids, then fill the table past full.
        issue(ACT_ARRIVE, 16'hFFFF, 8'd255, 16'hFFFF, 32'd0);
        issue(ACT_ARRIVE, 16'h0000, 8'd1, 16'd1, 32'd0);
        issue(ACT_ARRIVE, 16'h0000, 8'd255, 16'd2, 32'd0);
        for (int i = 3; i < ENTRIES; i++)
            issue(ACT_ARRIVE, 16'(i), 8'(i * 13), 16'(i % 3), 32'd0);
        issue(ACT_ARRIVE, 16'hABCD, 8'd9, 16'd3, 32'd0);
        issue(ACT_TICK, 16'd0, 8'd0, 16'd0, 32'hFFFF_FFFF);
        issue(ACT_TICK, 16'd0, 8'd0, 16'd0, 32'd0);
        issue(ACT_TICK, 16'd0, 8'd0, 16'd0, 32'd511);
        wait_idle();

        // Random phases, each under its own quantum; the last runs without gaps.
        for (int p = 0; p < 6; p++) begin
            write_quantum(p == 3 ? 8'($urandom_range(1, 255)) : quanta[p]);
            if (p == 5)
                gaps_on = 0;
            for (int n = 0; n < 200; n++)
                random_item(p == 2 ? 60 : 35);
            wait_idle();
        end
        write_quantum(QUANTUM_RESET);
        repeat (20) @(negedge clk);

        if (fails == 0)
            $display("tb_lottery_quantum_scheduler_core OK");
        else
            $display("tb_lottery_quantum_scheduler_core NOT OK");
        $finish;
    end

    initial begin
        #(12 * 3000000);
        $display("tb_lottery_quantum_scheduler_core NOT OK");
        $finish;
    end

endmodule

// File: files.f
design/lqs_pkg.sv
design/lottery_quantum_scheduler_core.sv
verif/lqs_checker.sv
verif/tb_lottery_quantum_scheduler_core.sv
